[hw/rtl/bresenham_line_stepper_core_assert.svh]
// Assertion macros for the line stepper core.
`ifndef BRESENHAM_LINE_STEPPER_CORE_ASSERT_SVH
`define BRESENHAM_LINE_STEPPER_CORE_ASSERT_SVH

`ifndef SYNTHESIS

// The consequent must hold in the same cycle as the antecedent.
`define BLS_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("%m: assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define BLS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("%m: assertion failed");

`else

`define BLS_ASSERT_SAME(label, clk, rst_n, ante, cons)
`define BLS_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

[hw/rtl/bls_pkg.sv]
// Shared types and constants for the line stepper core.
`default_nettype none

package bls_pkg;

    localparam int COORD_BITS_DEFAULT = 16;

    typedef enum logic [0:0] {
        CMD_START = 1'b0,
        CMD_NEXT  = 1'b1
    } cmd_t;

    typedef struct packed {
        logic dir_x_negative;
        logic dir_y_negative;
        logic x_is_major;
    } line_flags_t;

endpackage

`default_nettype wire

[hw/rtl/bresenham_line_stepper_core.sv]
// Bresenham line stepper: one pixel word out for every command word in.
//
// The slave channel takes command words: tuser selects start (load endpoints) or
// next (step along the line), tdata carries the four endpoint coordinates.
// Every command word gives exactly one result word on the master channel:
// tdata carries the pixel coordinates, tuser says whether a pixel was produced,
// and tlast marks the final endpoint of the line. A next command while no line
// is in progress gives a word with tuser low and zero coordinates.
// A word accepted into the input register (spans and directions are computed on
// entry) passes through the step logic into the result register and is shown.
// Throughput is one word per cycle while the receiver does not stall; the step
// logic updates the line state combinationally, so back-to-back commands on the
// same line do not stall.
// When the receiver stalls, the result register holds its word, the input
// register fills, and then s_tready drops until the result word is taken.
// Reset clears all line state and the valid flags of both registers; the block comes out idle.
`default_nettype none

`include "bresenham_line_stepper_core_assert.svh"

module bresenham_line_stepper_core
    import bls_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEFAULT,
    localparam int IN_BITS   = ((4 * COORD_BITS + 7) / 8) * 8,
    localparam int OUT_BITS  = ((2 * COORD_BITS + 7) / 8) * 8
)
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                s_tvalid,
    output logic                     s_tready,
    // Fields from bit 0 up: start_x, start_y, end_x, end_y, zero padding.
    input  wire logic [IN_BITS-1:0]  s_tdata,
    // Fields from bit 0 up: command.
    input  wire logic [0:0]          s_tuser,
    output logic                     m_tvalid,
    input  wire logic                m_tready,
    // Fields from bit 0 up: pixel_x, pixel_y, zero padding.
    output logic [OUT_BITS-1:0]      m_tdata,
    // Fields from bit 0 up: valid_res.
    output logic [0:0]               m_tuser,
    output logic                     m_tlast
);

    localparam int W = COORD_BITS;

    // Input decode ahead of the input register.
    logic signed [W-1:0] in_sx;
    logic signed [W-1:0] in_sy;
    logic signed [W-1:0] in_ex;
    logic signed [W-1:0] in_ey;
    logic signed [W:0]   in_dx;
    logic signed [W:0]   in_dy;
    logic        [W:0]   in_abs_dx;
    logic        [W:0]   in_abs_dy;
    line_flags_t         in_flags;

    // Input register.
    logic                in_valid_reg;
    cmd_t                cmd_reg;
    logic signed [W-1:0] start_x_reg;
    logic signed [W-1:0] start_y_reg;
    logic signed [W-1:0] new_major_end_reg;
    logic        [W-1:0] new_span_x_reg;
    logic        [W-1:0] new_span_y_reg;
    line_flags_t         new_flags_reg;

    // Line state.
    logic signed [W-1:0] cur_x_reg;
    logic signed [W-1:0] cur_y_reg;
    logic signed [W-1:0] major_end_reg;
    logic        [W-1:0] span_x_reg;
    logic        [W-1:0] span_y_reg;
    logic signed [W:0]   error_acc_reg;
    line_flags_t         flags_reg;
    logic                active_reg;

    logic signed [W-1:0] cur_x_next;
    logic signed [W-1:0] cur_y_next;
    logic signed [W-1:0] major_end_next;
    logic        [W-1:0] span_x_next;
    logic        [W-1:0] span_y_next;
    logic signed [W:0]   error_acc_next;
    line_flags_t         flags_next;
    logic                active_next;

    // Result register.
    logic                out_valid_reg;
    logic signed [W-1:0] pixel_x_reg;
    logic signed [W-1:0] pixel_y_reg;
    logic                valid_res_reg;
    logic                last_reg;

    logic signed [W-1:0] pixel_x_next;
    logic signed [W-1:0] pixel_y_next;
    logic                valid_res_next;
    logic                last_next;

    // Step inputs and outputs.
    logic                is_start;
    logic                emit;
    logic                work_fire;
    logic                in_fire;
    line_flags_t         sel_flags;
    logic signed [W-1:0] sel_x;
    logic signed [W-1:0] sel_y;
    logic signed [W-1:0] sel_major_end;
    logic        [W-1:0] sel_span_x;
    logic        [W-1:0] sel_span_y;
    logic signed [W:0]   sel_error;
    logic                step_fin;
    logic signed [W-1:0] step_x;
    logic signed [W-1:0] step_y;
    logic signed [W:0]   step_error;

    always_comb
    begin
        in_sx     = s_tdata[W-1:0];
        in_sy     = s_tdata[2*W-1:W];
        in_ex     = s_tdata[3*W-1:2*W];
        in_ey     = s_tdata[4*W-1:3*W];
        in_dx     = {in_ex[W-1], in_ex} - {in_sx[W-1], in_sx};
        in_dy     = {in_ey[W-1], in_ey} - {in_sy[W-1], in_sy};
        in_abs_dx = in_dx[W] ? (W+1)'(-in_dx) : in_dx;
        in_abs_dy = in_dy[W] ? (W+1)'(-in_dy) : in_dy;
        in_flags.dir_x_negative = in_dx[W] || (in_dx == '0);
        in_flags.dir_y_negative = in_dy[W] || (in_dy == '0);
        in_flags.x_is_major     = (in_abs_dx[W-1:0] > in_abs_dy[W-1:0]);
    end

    assign work_fire = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready  = !in_valid_reg || work_fire;
    assign in_fire   = s_tvalid && s_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            cmd_reg           <= cmd_t'(s_tuser[0]);
            start_x_reg       <= in_sx;
            start_y_reg       <= in_sy;
            new_major_end_reg <= in_flags.x_is_major ? in_ex : in_ey;
            new_span_x_reg    <= in_abs_dx[W-1:0];
            new_span_y_reg    <= in_abs_dy[W-1:0];
            new_flags_reg     <= in_flags;
        end
    end

    always_comb
    begin
        is_start      = (cmd_reg == CMD_START);
        emit          = is_start || active_reg;
        sel_flags     = is_start ? new_flags_reg : flags_reg;
        sel_x         = is_start ? start_x_reg : cur_x_reg;
        sel_y         = is_start ? start_y_reg : cur_y_reg;
        sel_major_end = is_start ? new_major_end_reg : major_end_reg;
        sel_span_x    = is_start ? new_span_x_reg : span_x_reg;
        sel_span_y    = is_start ? new_span_y_reg : span_y_reg;
        sel_error     = is_start ? '0 : error_acc_reg;
    end

    bls_step #(
        .COORD_BITS (COORD_BITS)
    ) u_step (
        .flags      (sel_flags),
        .cur_x      (sel_x),
        .cur_y      (sel_y),
        .major_end  (sel_major_end),
        .span_x     (sel_span_x),
        .span_y     (sel_span_y),
        .error_acc  (sel_error),
        .fin        (step_fin),
        .next_x     (step_x),
        .next_y     (step_y),
        .next_error (step_error)
    );

    always_comb
    begin
        cur_x_next     = cur_x_reg;
        cur_y_next     = cur_y_reg;
        major_end_next = major_end_reg;
        span_x_next    = span_x_reg;
        span_y_next    = span_y_reg;
        error_acc_next = error_acc_reg;
        flags_next     = flags_reg;
        active_next    = active_reg;
        pixel_x_next   = pixel_x_reg;
        pixel_y_next   = pixel_y_reg;
        valid_res_next = valid_res_reg;
        last_next      = last_reg;

        if (work_fire)
        begin
            if (emit)
            begin
                cur_x_next     = step_x;
                cur_y_next     = step_y;
                major_end_next = sel_major_end;
                span_x_next    = sel_span_x;
                span_y_next    = sel_span_y;
                error_acc_next = step_error;
                flags_next     = sel_flags;
                active_next    = !step_fin;
                pixel_x_next   = sel_x;
                pixel_y_next   = sel_y;
                valid_res_next = 1'b1;
                last_next      = step_fin;
            end
            else
            begin
                pixel_x_next   = '0;
                pixel_y_next   = '0;
                valid_res_next = 1'b0;
                last_next      = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_x_reg     <= '0;
            cur_y_reg     <= '0;
            major_end_reg <= '0;
            span_x_reg    <= '0;
            span_y_reg    <= '0;
            error_acc_reg <= '0;
            flags_reg     <= '0;
            active_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            cur_x_reg     <= cur_x_next;
            cur_y_reg     <= cur_y_next;
            major_end_reg <= major_end_next;
            span_x_reg    <= span_x_next;
            span_y_reg    <= span_y_next;
            error_acc_reg <= error_acc_next;
            flags_reg     <= flags_next;
            active_reg    <= active_next;
            if (work_fire)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        pixel_x_reg   <= pixel_x_next;
        pixel_y_reg   <= pixel_y_next;
        valid_res_reg <= valid_res_next;
        last_reg      <= last_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = OUT_BITS'({pixel_y_reg, pixel_x_reg});
    assign m_tuser  = valid_res_reg;
    assign m_tlast  = last_reg;

    `BLS_ASSERT_SAME(idle_word_is_empty, clk, rst_n, m_tvalid && !m_tuser[0], (m_tdata == '0) && !m_tlast)
    `BLS_ASSERT_NEXT(last_pixel_ends_line, clk, rst_n, work_fire && emit && step_fin, !active_reg)
    `BLS_ASSERT_SAME(stall_blocks_intake, clk, rst_n, in_valid_reg && m_tvalid && !m_tready, !s_tready)

endmodule

`default_nettype wire

[hw/rtl/bls_step.sv]
// Combinational Bresenham step: end-of-line test and the coordinates after one pixel.
`default_nettype none

module bls_step
    import bls_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEFAULT
)
(
    input  wire line_flags_t                   flags,
    input  wire logic signed [COORD_BITS-1:0]  cur_x,
    input  wire logic signed [COORD_BITS-1:0]  cur_y,
    input  wire logic signed [COORD_BITS-1:0]  major_end,
    input  wire logic        [COORD_BITS-1:0]  span_x,
    input  wire logic        [COORD_BITS-1:0]  span_y,
    input  wire logic signed [COORD_BITS:0]    error_acc,
    output logic                               fin,
    output logic signed [COORD_BITS-1:0]       next_x,
    output logic signed [COORD_BITS-1:0]       next_y,
    output logic signed [COORD_BITS:0]         next_error
);

    logic signed [COORD_BITS-1:0] major_coord;
    logic        [COORD_BITS-1:0] major_span;
    logic        [COORD_BITS-1:0] minor_span;
    logic signed [COORD_BITS+1:0] err_sum;
    logic signed [COORD_BITS+2:0] err_double;
    logic signed [COORD_BITS+2:0] major_wide;
    logic signed [COORD_BITS+1:0] err_less;
    logic                         minor_step;
    logic signed [COORD_BITS-1:0] step_x;
    logic signed [COORD_BITS-1:0] step_y;

    always_comb
    begin
        major_coord = flags.x_is_major ? cur_x : cur_y;
        major_span  = flags.x_is_major ? span_x : span_y;
        minor_span  = flags.x_is_major ? span_y : span_x;
        fin         = (major_coord == major_end);

        err_sum    = {error_acc[COORD_BITS], error_acc}
                   + $signed({2'b00, minor_span});
        err_double = $signed({err_sum, 1'b0});
        major_wide = $signed({3'b000, major_span});
        minor_step = (err_double >= major_wide);
        err_less   = err_sum - $signed({2'b00, major_span});
        next_error = minor_step ? err_less[COORD_BITS:0] : err_sum[COORD_BITS:0];

        step_x = flags.dir_x_negative ? '1 : COORD_BITS'(1);
        step_y = flags.dir_y_negative ? '1 : COORD_BITS'(1);

        if (flags.x_is_major)
        begin
            next_x = cur_x + step_x;
            next_y = minor_step ? (cur_y + step_y) : cur_y;
        end
        else
        begin
            next_x = minor_step ? (cur_x + step_x) : cur_x;
            next_y = cur_y + step_y;
        end
    end

endmodule

`default_nettype wire

[tb/sv/bresenham_line_stepper_core_tb.sv]
// Self-checking testbench for the line stepper core: random and directed command streams.
`timescale 1ns / 1ps

module bresenham_line_stepper_core_tb;
    import bls_pkg::*;

    localparam int CB       = COORD_BITS_DEFAULT;
    localparam int IN_BITS  = ((4 * CB + 7) / 8) * 8;
    localparam int OUT_BITS = ((2 * CB + 7) / 8) * 8;
    localparam int NUM_ITEMS = 1550;
    localparam int CMAX = (1 << (CB - 1)) - 1;
    localparam int CMIN = -(1 << (CB - 1));

    typedef struct packed {
        cmd_t                  op;
        logic signed [CB-1:0]  sx;
        logic signed [CB-1:0]  sy;
        logic signed [CB-1:0]  ex;
        logic signed [CB-1:0]  ey;
    } line_cmd_t;

    typedef struct packed {
        logic signed [CB-1:0]  x;
        logic signed [CB-1:0]  y;
        logic                  drawn;
        logic                  fin;
    } pixel_t;

    typedef enum int {
        RX_FREE,
        RX_COIN,
        RX_BEAT,
        RX_SLOW
    } rx_mode_t;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                s_tvalid = 1'b0;
    logic                s_tready;
    logic [IN_BITS-1:0]  s_tdata = '0;
    logic [0:0]          s_tuser = CMD_NEXT;
    logic                m_tvalid;
    logic                m_tready = 1'b0;
    logic [OUT_BITS-1:0] m_tdata;
    logic [0:0]          m_tuser;
    logic                m_tlast;

    line_cmd_t cmd_q[$];
    pixel_t    pending_pixels[$];
    line_cmd_t cur_cmd;
    pixel_t    want;

    int ln_x, ln_y, ln_major_end, ln_span_x, ln_span_y, ln_err;
    bit ln_neg_x, ln_neg_y, ln_x_major, ln_busy;

    int fail_count = 0;
    int cmds_sent = 0;
    int starts_sent = 0;
    int pixels_seen = 0;
    int ends_seen = 0;
    int idle_seen = 0;
    int burst_left = 0;
    int gap_left = 0;
    int rx_left = 0;
    int rx_phase = 0;
    rx_mode_t rx_mode = RX_FREE;
    logic hold_rx = 1'b0;

    bresenham_line_stepper_core #(.COORD_BITS(CB)) dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic pixel_t plot_pixel(line_cmd_t c);
        pixel_t p;
        int dx;
        int dy;
        int maj;
        int major_span;
        int minor_span;
        p = '0;
        if (c.op == CMD_START)
        begin
            dx = int'(c.ex) - int'(c.sx);
            dy = int'(c.ey) - int'(c.sy);
            ln_neg_x = !(dx > 0);
            ln_neg_y = !(dy > 0);
            ln_span_x = (dx < 0) ? -dx : dx;
            ln_span_y = (dy < 0) ? -dy : dy;
            ln_x_major = ln_span_x > ln_span_y;
            ln_major_end = ln_x_major ? int'(c.ex) : int'(c.ey);
            ln_x = int'(c.sx);
            ln_y = int'(c.sy);
            ln_err = 0;
            ln_busy = 1'b1;
        end
        else if (!ln_busy)
        begin
            return p;
        end
        maj = ln_x_major ? ln_x : ln_y;
        major_span = ln_x_major ? ln_span_x : ln_span_y;
        minor_span = ln_x_major ? ln_span_y : ln_span_x;
        p.x = ln_x[CB-1:0];
        p.y = ln_y[CB-1:0];
        p.drawn = 1'b1;
        p.fin = (maj == ln_major_end);
        if (p.fin)
        begin
            ln_busy = 1'b0;
            return p;
        end
        ln_err += minor_span;
        if (2 * ln_err >= major_span)
        begin
            ln_err -= major_span;
            if (ln_x_major)
                ln_y += ln_neg_y ? -1 : 1;
            else
                ln_x += ln_neg_x ? -1 : 1;
        end
        if (ln_x_major)
            ln_x += ln_neg_x ? -1 : 1;
        else
            ln_y += ln_neg_y ? -1 : 1;
        return p;
    endfunction

    function automatic void queue_cmd(cmd_t op, int sx, int sy, int ex, int ey);
        line_cmd_t c;
        c.op = op;
        c.sx = sx[CB-1:0];
        c.sy = sy[CB-1:0];
        c.ex = ex[CB-1:0];
        c.ey = ey[CB-1:0];
        cmd_q.insert(cmd_q.size(), c);
    endfunction

    function automatic void queue_steps(int n);
        for (int i = 0; i < n; i++)
            queue_cmd(CMD_NEXT, $urandom(), $urandom(), $urandom(), $urandom());
    endfunction

    function automatic int reach(int base, int d);
        if (base + d > CMAX || base + d < CMIN)
            return base - d;
        return base + d;
    endfunction

    task automatic note_failure(input string msg);
        $display("%0t ns: %s", $time, msg);
        fail_count++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tdata <= '0;
            s_tuser <= CMD_NEXT;
        end
        else
        begin
            if (s_tvalid && s_tready)
            begin
                pending_pixels.insert(pending_pixels.size(), plot_pixel(cur_cmd));
                cmds_sent++;
                if (cur_cmd.op == CMD_START)
                    starts_sent++;
            end
            if (!s_tvalid || s_tready)
            begin
                if (gap_left > 0 && !hold_rx)
                begin
                    gap_left--;
                    s_tvalid <= 1'b0;
                end
                else if (cmd_q.size() > 0)
                begin
                    cur_cmd = cmd_q.pop_front();
                    s_tdata <= {cur_cmd.ey, cur_cmd.ex, cur_cmd.sy, cur_cmd.sx};
                    s_tuser <= cur_cmd.op;
                    s_tvalid <= 1'b1;
                    if (burst_left > 0)
                    begin
                        burst_left--;
                    end
                    else
                    begin
                        burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 120)
                                                                 : $urandom_range(1, 16);
                        gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 7);
                    end
                end
                else
                begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tready <= 1'b0;
        end
        else
        begin
            if (rx_left == 0)
            begin
                rx_mode = rx_mode_t'($urandom_range(0, 3));
                rx_left = $urandom_range(20, 120);
            end
            else
            begin
                rx_left--;
            end
            rx_phase++;
            case (rx_mode)
                RX_FREE: m_tready <= !hold_rx;
                RX_COIN: m_tready <= !hold_rx && $urandom_range(0, 1);
                RX_BEAT: m_tready <= !hold_rx && (rx_phase % 3 != 0);
                default: m_tready <= !hold_rx && ($urandom_range(0, 5) == 0);
            endcase
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            if (m_tuser[0] === 1'b1)
                pixels_seen++;
            else
                idle_seen++;
            if (m_tlast === 1'b1)
                ends_seen++;
            if (pending_pixels.size() == 0)
            begin
                note_failure($sformatf("result word with nothing pending: x=%0d y=%0d",
                                       $signed(m_tdata[CB-1:0]),
                                       $signed(m_tdata[2*CB-1:CB])));
            end
            else
            begin
                want = pending_pixels.pop_front();
                if (m_tdata[CB-1:0] !== want.x)
                    note_failure($sformatf("pixel_x got %0d, expected %0d",
                                           $signed(m_tdata[CB-1:0]), want.x));
                if (m_tdata[2*CB-1:CB] !== want.y)
                    note_failure($sformatf("pixel_y got %0d, expected %0d",
                                           $signed(m_tdata[2*CB-1:CB]), want.y));
                if (m_tuser[0] !== want.drawn)
                    note_failure($sformatf("valid_res got %b, expected %b",
                                           m_tuser[0], want.drawn));
                if (m_tlast !== want.fin)
                    note_failure($sformatf("last got %b, expected %b", m_tlast, want.fin));
            end
        end
    end

    initial
    begin
        wait (cmds_sent >= 700);
        @(posedge clk);
        hold_rx <= 1'b1;
        repeat (400) @(posedge clk);
        hold_rx <= 1'b0;
    end

    initial
    begin
        #5_000_000;
        $display("Regression FAIL");
        $finish;
    end

    initial
    begin
        int sel;
        int reach_span;
        int sx;
        int sy;
        int ex;
        int ey;
        int dx;
        int dy;
        int steps;

        // Idle next commands, then a single-pixel line.
        queue_cmd(CMD_NEXT, -1, -1, -1, -1);
        queue_cmd(CMD_NEXT, 0, 0, 0, 0);
        queue_cmd(CMD_START, 0, 0, 0, 0);
        queue_cmd(CMD_NEXT, 7, 7, 7, 7);
        // Full-range diagonals in both directions, each abandoned by a new start.
        queue_cmd(CMD_START, CMIN, CMIN, CMAX, CMAX);
        queue_steps(3);
        queue_cmd(CMD_START, CMAX, CMAX, CMIN, CMIN);
        queue_steps(2);
        // Short lines with an endpoint on the coordinate limits, one of each major axis.
        queue_cmd(CMD_START, CMAX - 3, CMIN + 1, CMAX, CMIN);
        queue_steps(4);
        queue_cmd(CMD_START, CMIN, CMAX, CMIN + 1, CMAX - 3);
        queue_steps(3);
        // Vertical line running downward.
        queue_cmd(CMD_START, 5, 5, 5, 1);
        queue_steps(4);

        while (cmd_q.size() < NUM_ITEMS)
        begin
            sel = $urandom_range(0, 99);
            if (sel < 8)
            begin
                queue_cmd(CMD_START, $urandom(), $urandom(), $urandom(), $urandom());
                queue_steps($urandom_range(0, 6));
            end
            else if (sel < 14)
            begin
                queue_steps($urandom_range(1, 3));
            end
            else
            begin
                reach_span = ($urandom_range(0, 19) == 0) ? 200 : $urandom_range(0, 12);
                sx = $signed(16'($urandom()));
                sy = $signed(16'($urandom()));
                dx = $urandom_range(0, 2 * reach_span) - reach_span;
                dy = $urandom_range(0, 2 * reach_span) - reach_span;
                ex = reach(sx, dx);
                ey = reach(sy, dy);
                steps = (dx < 0 ? -dx : dx) > (dy < 0 ? -dy : dy) ? (dx < 0 ? -dx : dx)
                                                                  : (dy < 0 ? -dy : dy);
                sel = $urandom_range(0, 99);
                if (sel < 15)
                    steps += $urandom_range(1, 2);
                else if (sel < 30)
                    steps = $urandom_range(0, steps);
                queue_cmd(CMD_START, sx, sy, ex, ey);
                queue_steps(steps);
            end
        end

        repeat (6) @(posedge clk);
        @(negedge clk) rst_n = 1'b1;

        while (cmd_q.size() != 0 || s_tvalid)
            @(posedge clk);
        while (pending_pixels.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);

        $display("Sent %0d command words: %0d starts, %0d next steps.",
                 cmds_sent, starts_sent, cmds_sent - starts_sent);
        $display("Checked %0d pixels (%0d line ends) and %0d idle words; %0d mismatches.",
                 pixels_seen, ends_seen, idle_seen, fail_count);
        if (fail_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
